// ===== hdl/bsc_pkg.sv =====
`default_nettype none
package bsc_pkg;

	localparam int MAX_PROCS  = 8;
	localparam int MAX_RES    = 8;
	localparam int UNIT_WIDTH = 16;

	localparam int PROC_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RES_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
	localparam int RCNT_W  = $clog2(MAX_RES + 1);
	localparam int TBL_AW  = PROC_W + RES_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 3;
	localparam int AMT_W    = 16;
	localparam int STATUS_W = 2;
	localparam int PID_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	typedef logic [UNIT_WIDTH-1:0] unit_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 3'd0,
		FN_CLAIM = 3'd1,
		FN_FREE  = 3'd2,
		FN_REQ   = 3'd3,
		FN_CHECK = 3'd4
	} func_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SAFE   = 2'd0,
		ST_UNSAFE = 2'd1,
		ST_EXCEED = 2'd2,
		ST_WAIT   = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 1'b1;

	localparam logic [CFG_DATA_W-1:0] NUM_PROCS_RST = CFG_DATA_W'(MAX_PROCS);
	localparam logic [CFG_DATA_W-1:0] NUM_RES_RST   = CFG_DATA_W'(MAX_RES);

	function automatic logic [PCNT_W-1:0] eff_procs(input logic [CFG_DATA_W-1:0] v);
		logic [PCNT_W-1:0] res;
		if (v == '0) begin
			res = PCNT_W'(1);
		end else if (int'(v) > MAX_PROCS) begin
			res = PCNT_W'(MAX_PROCS);
		end else begin
			res = PCNT_W'(v);
		end
		return res;
	endfunction

	function automatic logic [RCNT_W-1:0] eff_res(input logic [CFG_DATA_W-1:0] v);
		logic [RCNT_W-1:0] res;
		if (v == '0) begin
			res = RCNT_W'(1);
		end else if (int'(v) > MAX_RES) begin
			res = RCNT_W'(MAX_RES);
		end else begin
			res = RCNT_W'(v);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bsc_if.sv =====
`default_nettype none
interface bsc_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [bsc_pkg::FUNC_W-1:0]   func;
	logic [bsc_pkg::IDX_W-1:0]    process_index;
	logic [bsc_pkg::IDX_W-1:0]    resource_index;
	logic [bsc_pkg::AMT_W-1:0]    amount;
	logic                         request_last;

	modport source (output valid, func, process_index, resource_index, amount, request_last,
		input ready);
	modport sink (input valid, func, process_index, resource_index, amount, request_last,
		output ready);
endinterface

interface bsc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bsc_pkg::STATUS_W-1:0] status;
	logic [bsc_pkg::PID_W-1:0]    process_id;
	logic                         last;

	modport source (output valid, status, process_id, last, input ready);
	modport sink (input valid, status, process_id, last, output ready);
endinterface

interface bsc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bsc_pkg::CFG_IDX_W-1:0]  index;
	logic [bsc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsc_ram.sv =====
`default_nettype none
module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/bsc_alu.sv =====
`default_nettype none
module bsc_alu (
	input  wire logic [bsc_pkg::UNIT_WIDTH-1:0] a,
	input  wire logic [bsc_pkg::UNIT_WIDTH-1:0] b,
	input  wire logic                           sub,
	input  wire logic [bsc_pkg::UNIT_WIDTH-1:0] c,
	output logic      [bsc_pkg::UNIT_WIDTH:0]   sum,
	output logic      [bsc_pkg::UNIT_WIDTH-1:0] sat,
	output logic                                c_gt,
	output logic                                c_lt
);

	always_comb begin
		if (sub) begin
			sum = {1'b0, a} - {1'b0, b};
		end else begin
			sum = {1'b0, a} + {1'b0, b};
		end
		sat  = sum[bsc_pkg::UNIT_WIDTH] ? '1 : sum[bsc_pkg::UNIT_WIDTH-1:0];
		c_gt = {1'b0, c} > sum;
		c_lt = {1'b0, c} < sum;
	end

endmodule
`default_nettype wire

// ===== hdl/bankers_safety_checker_unit.sv =====
`default_nettype none
// Banker's algorithm safety checker. Items on cmd load the allocation, claim and
// available tables one element per cycle while idle, stage request elements, or start
// a safety check. Results leave on rsp; cfg sets the process and resource counts,
// which the user must set only while idle; the unit does not enforce it. Table
// writes and request elements without the last flag give no result. A safety check
// makes up to np passes over the processes, testing each resource element in a single
// add and compare unit behind the table read port; finished processes are skipped. A
// request first scans its elements against need and available, then writes the
// allocation element by element, runs the check, and writes it back the same way if
// the state is unsafe. The safe order then leaves at one item per cycle while the
// receiver is ready, or a single status item is sent. cmd is not ready until the
// last result is loaded into the output register. A stalled receiver holds that
// register and the sequencer waits. Reset clears the tables through per-entry valid
// bits, so no clearing pass is needed, and sets both counts to their maximum.
module bankers_safety_checker_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsc_cfg_if.sink    cfg,
	bsc_cmd_if.sink    cmd,
	bsc_rsp_if.source  rsp
);

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_RQ_RD   = 10'b00_0000_0010,
		S_RQ_EX   = 10'b00_0000_0100,
		S_AP_RD   = 10'b00_0000_1000,
		S_AP_EX   = 10'b00_0001_0000,
		S_SC_INIT = 10'b00_0010_0000,
		S_SC_RD   = 10'b00_0100_0000,
		S_SC_EX   = 10'b00_1000_0000,
		S_SC_PASS = 10'b01_0000_0000,
		S_EMIT    = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [bsc_pkg::CFG_DATA_W-1:0] np_raw_q, nr_raw_q;
	logic [bsc_pkg::PCNT_W-1:0]     np_eff;
	logic [bsc_pkg::RCNT_W-1:0]     nr_eff;

	bsc_pkg::unit_t free_q [bsc_pkg::MAX_RES];
	bsc_pkg::unit_t pend_q [bsc_pkg::MAX_RES];
	bsc_pkg::unit_t work_q [bsc_pkg::MAX_RES];
	bsc_pkg::unit_t tmp_q  [bsc_pkg::MAX_RES];
	logic [bsc_pkg::PROC_W-1:0] order_q [bsc_pkg::MAX_PROCS];
	logic [bsc_pkg::MAX_PROCS-1:0] done_q;
	logic [bsc_pkg::TBL_DEPTH-1:0] alloc_vld_q, claim_vld_q;
	logic alloc_rv_q, claim_rv_q;

	logic [bsc_pkg::RES_W-1:0]  r_q;
	logic [bsc_pkg::PROC_W-1:0] pcnt_q;
	logic [bsc_pkg::PCNT_W-1:0] count_q;
	logic [bsc_pkg::PROC_W-1:0] ecnt_q;
	logic progress_q, exceed_q, wait_q, req_mode_q, rollback_q, single_q;
	logic [bsc_pkg::PID_W-1:0] req_p_q;
	bsc_pkg::status_t res_status_q;
	logic [bsc_pkg::PID_W-1:0] res_pid_q;

	logic out_valid_q;
	bsc_pkg::status_t out_status_q;
	logic [bsc_pkg::PID_W-1:0] out_pid_q;
	logic out_last_q;

	logic cmd_fire, cfg_fire, p_ok, r_ok, emit_go;
	logic last_r, last_p, last_e, exceed_n, wait_n;
	bsc_pkg::unit_t amt;
	logic [bsc_pkg::PROC_W-1:0] cmd_p, rd_p;
	logic [bsc_pkg::RES_W-1:0]  cmd_r;
	logic [bsc_pkg::TBL_AW-1:0] rd_addr, alloc_waddr, claim_waddr;
	logic alloc_we, claim_we;
	bsc_pkg::unit_t alloc_wdata, alloc_rd, claim_rd, alloc_v, claim_v, amax;
	bsc_pkg::unit_t alu_a, alu_b, alu_c, alu_sat;
	logic [bsc_pkg::UNIT_WIDTH:0] alu_sum;
	logic alu_sub, alu_c_gt, alu_c_lt;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.process_id = out_pid_q;
	assign rsp.last = out_last_q;

	always_comb begin
		np_eff   = bsc_pkg::eff_procs(np_raw_q);
		nr_eff   = bsc_pkg::eff_res(nr_raw_q);
		cmd_fire = cmd.valid && cmd.ready;
		cfg_fire = cfg.valid && cfg.ready;
		amt      = bsc_pkg::UNIT_WIDTH'(cmd.amount);
		p_ok     = int'(cmd.process_index) < bsc_pkg::MAX_PROCS;
		r_ok     = int'(cmd.resource_index) < bsc_pkg::MAX_RES;
		cmd_p    = bsc_pkg::PROC_W'(cmd.process_index);
		cmd_r    = bsc_pkg::RES_W'(cmd.resource_index);
		last_r   = (bsc_pkg::RCNT_W'(r_q) + bsc_pkg::RCNT_W'(1)) == nr_eff;
		last_p   = (bsc_pkg::PCNT_W'(pcnt_q) + bsc_pkg::PCNT_W'(1)) == np_eff;
		last_e   = (bsc_pkg::PCNT_W'(ecnt_q) + bsc_pkg::PCNT_W'(1)) == np_eff;
		emit_go  = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

		rd_p    = (state_q == S_SC_RD) ? pcnt_q : bsc_pkg::PROC_W'(req_p_q);
		rd_addr = {rd_p, r_q};
		alloc_v = alloc_rv_q ? alloc_rd : '0;
		claim_v = claim_rv_q ? claim_rd : '0;
		amax    = (claim_v > alloc_v) ? claim_v : alloc_v;

		case (state_q)
			S_RQ_EX: begin
				alu_a = pend_q[r_q];
				alu_b = alloc_v;
				alu_sub = 1'b0;
				alu_c = amax;
			end
			S_AP_EX: begin
				alu_a = alloc_v;
				alu_b = pend_q[r_q];
				alu_sub = rollback_q;
				alu_c = claim_v;
			end
			default: begin
				alu_a = alloc_v;
				alu_b = work_q[r_q];
				alu_sub = 1'b0;
				alu_c = claim_v;
			end
		endcase

		exceed_n = exceed_q || alu_c_lt;
		wait_n   = wait_q || (pend_q[r_q] > free_q[r_q]);

		if (state_q == S_AP_EX) begin
			alloc_we    = 1'b1;
			alloc_waddr = {bsc_pkg::PROC_W'(req_p_q), r_q};
			alloc_wdata = alu_sum[bsc_pkg::UNIT_WIDTH-1:0];
		end else begin
			alloc_we    = cmd_fire && (cmd.func == bsc_pkg::FN_ALLOC) && p_ok && r_ok;
			alloc_waddr = {cmd_p, cmd_r};
			alloc_wdata = amt;
		end
		claim_we    = cmd_fire && (cmd.func == bsc_pkg::FN_CLAIM) && p_ok && r_ok;
		claim_waddr = {cmd_p, cmd_r};
	end

	bsc_ram #(
		.WIDTH(bsc_pkg::UNIT_WIDTH),
		.DEPTH(bsc_pkg::TBL_DEPTH)
	) u_alloc_ram (
		.clk(clk),
		.we(alloc_we),
		.waddr(alloc_waddr),
		.wdata(alloc_wdata),
		.raddr(rd_addr),
		.rdata(alloc_rd)
	);

	bsc_ram #(
		.WIDTH(bsc_pkg::UNIT_WIDTH),
		.DEPTH(bsc_pkg::TBL_DEPTH)
	) u_claim_ram (
		.clk(clk),
		.we(claim_we),
		.waddr(claim_waddr),
		.wdata(amt),
		.raddr(rd_addr),
		.rdata(claim_rd)
	);

	bsc_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.sub(alu_sub),
		.c(alu_c),
		.sum(alu_sum),
		.sat(alu_sat),
		.c_gt(alu_c_gt),
		.c_lt(alu_c_lt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			np_raw_q    <= bsc_pkg::NUM_PROCS_RST;
			nr_raw_q    <= bsc_pkg::NUM_RES_RST;
			for (int i = 0; i < bsc_pkg::MAX_RES; i++) begin
				free_q[i] <= '0;
				pend_q[i] <= '0;
			end
			done_q      <= '0;
			alloc_vld_q <= '0;
			claim_vld_q <= '0;
			r_q         <= '0;
			pcnt_q      <= '0;
			count_q     <= '0;
			ecnt_q      <= '0;
			progress_q  <= 1'b0;
			exceed_q    <= 1'b0;
			wait_q      <= 1'b0;
			req_mode_q  <= 1'b0;
			rollback_q  <= 1'b0;
			single_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg.index == bsc_pkg::CFG_NUM_PROCS) begin
					np_raw_q <= cfg.data;
				end else if (cfg.index == bsc_pkg::CFG_NUM_RES) begin
					nr_raw_q <= cfg.data;
				end
			end
			if (alloc_we) begin
				alloc_vld_q[alloc_waddr] <= 1'b1;
			end
			if (claim_we) begin
				claim_vld_q[claim_waddr] <= 1'b1;
			end
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (cmd.func)
							bsc_pkg::FN_FREE: begin
								if (r_ok) begin
									free_q[cmd_r] <= amt;
								end
							end
							bsc_pkg::FN_CHECK: begin
								req_mode_q <= 1'b0;
								state_q    <= S_SC_INIT;
							end
							bsc_pkg::FN_REQ: begin
								if (r_ok) begin
									pend_q[cmd_r] <= amt;
								end
								if (cmd.request_last) begin
									req_mode_q <= 1'b1;
									r_q        <= '0;
									exceed_q   <= 1'b0;
									wait_q     <= 1'b0;
									if (!p_ok) begin
										single_q <= 1'b1;
										state_q  <= S_EMIT;
									end else begin
										state_q  <= S_RQ_RD;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RQ_RD: begin
					state_q <= S_RQ_EX;
				end
				S_RQ_EX: begin
					exceed_q <= exceed_n;
					wait_q   <= wait_n;
					if (last_r) begin
						r_q <= '0;
						if (exceed_n || wait_n) begin
							single_q <= 1'b1;
							state_q  <= S_EMIT;
						end else begin
							rollback_q <= 1'b0;
							state_q    <= S_AP_RD;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_RQ_RD;
					end
				end
				S_AP_RD: begin
					state_q <= S_AP_EX;
				end
				S_AP_EX: begin
					if (rollback_q) begin
						free_q[r_q] <= free_q[r_q] + pend_q[r_q];
					end else begin
						free_q[r_q] <= free_q[r_q] - pend_q[r_q];
					end
					if (last_r) begin
						r_q     <= '0;
						state_q <= rollback_q ? S_EMIT : S_SC_INIT;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_AP_RD;
					end
				end
				S_SC_INIT: begin
					done_q     <= '0;
					count_q    <= '0;
					pcnt_q     <= '0;
					r_q        <= '0;
					progress_q <= 1'b0;
					state_q    <= S_SC_RD;
				end
				S_SC_RD: begin
					if (done_q[pcnt_q]) begin
						r_q <= '0;
						if (last_p) begin
							state_q <= S_SC_PASS;
						end else begin
							pcnt_q  <= pcnt_q + 1'b1;
						end
					end else begin
						state_q <= S_SC_EX;
					end
				end
				S_SC_EX: begin
					if (alu_c_gt || last_r) begin
						if (!alu_c_gt) begin
							done_q[pcnt_q] <= 1'b1;
							count_q        <= count_q + 1'b1;
							progress_q     <= 1'b1;
						end
						r_q <= '0;
						if (last_p) begin
							state_q <= S_SC_PASS;
						end else begin
							pcnt_q  <= pcnt_q + 1'b1;
							state_q <= S_SC_RD;
						end
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_SC_PASS: begin
					pcnt_q     <= '0;
					r_q        <= '0;
					progress_q <= 1'b0;
					if (count_q == np_eff) begin
						single_q <= 1'b0;
						ecnt_q   <= '0;
						state_q  <= S_EMIT;
					end else if (!progress_q) begin
						single_q <= 1'b1;
						if (req_mode_q) begin
							rollback_q <= 1'b1;
							state_q    <= S_AP_RD;
						end else begin
							state_q    <= S_EMIT;
						end
					end else begin
						state_q <= S_SC_RD;
					end
				end
				S_EMIT: begin
					if (req_mode_q) begin
						for (int i = 0; i < bsc_pkg::MAX_RES; i++) begin
							pend_q[i] <= '0;
						end
					end
					if (emit_go) begin
						out_valid_q <= 1'b1;
						ecnt_q      <= ecnt_q + 1'b1;
						if (single_q || last_e) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		alloc_rv_q <= alloc_vld_q[rd_addr];
		claim_rv_q <= claim_vld_q[rd_addr];

		if (state_q == S_SC_EX && !alu_c_gt) begin
			tmp_q[r_q] <= alu_sat;
			if (last_r) begin
				for (int i = 0; i < bsc_pkg::MAX_RES; i++) begin
					work_q[i] <= (bsc_pkg::RES_W'(i) == r_q) ? alu_sat : tmp_q[i];
				end
				order_q[count_q[bsc_pkg::PROC_W-1:0]] <= pcnt_q;
			end
		end
		if (state_q == S_SC_INIT) begin
			for (int i = 0; i < bsc_pkg::MAX_RES; i++) begin
				work_q[i] <= free_q[i];
			end
		end

		if (cmd_fire && cmd.func == bsc_pkg::FN_CHECK) begin
			res_pid_q <= '0;
		end
		if (cmd_fire && cmd.func == bsc_pkg::FN_REQ && cmd.request_last) begin
			req_p_q      <= cmd.process_index;
			res_pid_q    <= cmd.process_index;
			res_status_q <= bsc_pkg::ST_EXCEED;
		end
		if (state_q == S_RQ_EX && last_r) begin
			res_status_q <= exceed_n ? bsc_pkg::ST_EXCEED : bsc_pkg::ST_WAIT;
		end
		if (state_q == S_SC_PASS) begin
			res_status_q <= bsc_pkg::ST_UNSAFE;
		end

		if (emit_go) begin
			if (single_q) begin
				out_status_q <= res_status_q;
				out_pid_q    <= res_pid_q;
				out_last_q   <= 1'b1;
			end else begin
				out_status_q <= bsc_pkg::ST_SAFE;
				out_pid_q    <= bsc_pkg::PID_W'(order_q[ecnt_q]);
				out_last_q   <= last_e;
			end
		end
	end

endmodule
`default_nettype wire
